// ----- sv/fasr_pkg.sv -----
package fasr_pkg;

  localparam int unsigned InWidth  = 32;
  localparam int unsigned MagWidth = InWidth + 1;
  localparam int unsigned OutWidth = 64;
  localparam int unsigned CntWidth = $clog2(MagWidth + 1);

  typedef enum logic [1:0] {
    OpReduce = 2'd0,
    OpAdd    = 2'd1,
    OpSub    = 2'd2,
    OpNone   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StZeroDen  = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    SIdle,
    SGcdStart,
    SGcdWait,
    SDivAStart,
    SDivAWait,
    SDivBStart,
    SDivBWait,
    SMul1,
    SMul2,
    SMul3,
    SSum,
    SOut
  } state_e;

  typedef struct packed {
    logic                start;
    logic [MagWidth-1:0] dividend;
    logic [MagWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [MagWidth-1:0] quotient;
    logic [MagWidth-1:0] remainder;
  } div_rsp_t;

endpackage

// ----- sv/fasr_if.sv -----
interface fasr_in_if;
  import fasr_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          opcode;
  logic [InWidth-1:0]  left_num;
  logic [InWidth-1:0]  left_den;
  logic [InWidth-1:0]  right_num;
  logic [InWidth-1:0]  right_den;
  modport source (output valid, opcode, left_num, left_den, right_num, right_den, input ready);
  modport sink   (input valid, opcode, left_num, left_den, right_num, right_den, output ready);
endinterface

interface fasr_out_if;
  import fasr_pkg::*;
  logic                valid;
  logic                ready;
  logic [OutWidth-1:0] result_num;
  logic [OutWidth-1:0] result_den;
  logic [1:0]          status;
  modport source (output valid, result_num, result_den, status, input ready);
  modport sink   (input valid, result_num, result_den, status, output ready);
endinterface

// ----- sv/fasr_divider.sv -----
module fasr_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fasr_pkg::div_req_t  req_i,
  output fasr_pkg::div_rsp_t  rsp_o
);
  import fasr_pkg::*;

  logic [MagWidth-1:0] quo_q, quo_d, rem_q, rem_d, dvs_q, dvs_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [MagWidth:0]   trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[MagWidth-1]} - {1'b0, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = CntWidth'(MagWidth);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[MagWidth]) begin
        rem_d = trial[MagWidth-1:0];
        quo_d = {quo_q[MagWidth-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[MagWidth-2:0], quo_q[MagWidth-1]};
        quo_d = {quo_q[MagWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  ap_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without busy");
  ap_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider busy at done");
  ap_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy_q && !req_i.start) |=> !busy_q) else $error("divider started itself");

endmodule

// ----- sv/fraction_add_sub_reduce_top.sv -----
// Fraction add, subtract and reduce.
// The input channel carries an opcode and two signed fractions; the output
// channel carries one result fraction and a status for each input beat.
// Reduce divides the first fraction by the gcd of its magnitudes. Add and
// subtract bring both fractions over d1/g*d2 and leave the result unreduced.
// A zero denominator gives status 1, an overflowing sum or difference
// status 2, both with a zero fraction; opcode 3 gives a zero fraction.
// All division goes through one restoring divider of 33 bits, one quotient
// bit a cycle. The gcd takes one division per Euclidean step (at most
// about 47 steps), then two exact divisions follow, and add or subtract
// use one 33 by 32 bit multiplier three times. A zero denominator or
// opcode 3 goes straight to the output state. One item is in flight at
// a time and ready is low meanwhile.
// The result is held in an output register until the receiver takes it; a
// stalled receiver holds the block, which accepts nothing until then.
// Reset returns the sequencer to idle with no beat pending.
module fraction_add_sub_reduce_top (
  input  logic  clk_i,
  input  logic  rst_ni,
  fasr_in_if.sink    in_i,
  fasr_out_if.source out_o
);
  import fasr_pkg::*;

  state_e state_q, state_d;
  div_req_t dreq;
  div_rsp_t drsp;

  logic [1:0] op_q;
  logic signed [InWidth-1:0] n1_q, d1_q, n2_q, d2_q;
  logic [MagWidth-1:0] a_q, b_q, g_q, qa_q, qb_q;
  logic [OutWidth-1:0] p1_q, p2_q, den_q;
  logic [OutWidth-1:0] rnum_q, rden_q;
  logic [1:0] status_q;
  logic vld_q;

  logic [MagWidth-1:0] ma_in, mb_in;
  logic signed [MagWidth-1:0] sa, sb, mul_a;
  logic signed [InWidth-1:0] mul_b;
  logic signed [MagWidth+InWidth-1:0] mul_p;
  logic [OutWidth-1:0] sum;
  logic ovf;
  logic load;

  function automatic logic [MagWidth-1:0] mag(input logic signed [InWidth-1:0] v);
    logic signed [MagWidth-1:0] e;
    e = MagWidth'(v);
    return e[MagWidth-1] ? -e : e;
  endfunction

  assign load = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == SIdle) && !vld_q;
  assign ma_in = (op_e'(in_i.opcode) == OpReduce) ? mag(in_i.left_num) : mag(in_i.left_den);
  assign mb_in = (op_e'(in_i.opcode) == OpReduce) ? mag(in_i.left_den) : mag(in_i.right_den);

  // Signed quotients: exact division by g, so the sign follows the operand.
  always_comb begin
    if (op_e'(op_q) == OpReduce) begin
      sa = n1_q[InWidth-1] ? -qa_q : qa_q;
      sb = d1_q[InWidth-1] ? -qb_q : qb_q;
    end else begin
      sa = d2_q[InWidth-1] ? -qa_q : qa_q;
      sb = d1_q[InWidth-1] ? -qb_q : qb_q;
    end
  end

  always_comb begin
    mul_a = sb;
    mul_b = d2_q;
    case (state_q)
      SMul1:   begin mul_a = sb; mul_b = d2_q; end
      SMul2:   begin mul_a = sa; mul_b = n1_q; end
      SMul3:   begin mul_a = sb; mul_b = n2_q; end
      default: begin mul_a = sb; mul_b = d2_q; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  always_comb begin
    if (op_e'(op_q) == OpAdd) begin
      sum = p1_q + p2_q;
      ovf = (~(p1_q[OutWidth-1] ^ p2_q[OutWidth-1])) & (p1_q[OutWidth-1] ^ sum[OutWidth-1]);
    end else begin
      sum = p1_q - p2_q;
      ovf = (p1_q[OutWidth-1] ^ p2_q[OutWidth-1]) & (p1_q[OutWidth-1] ^ sum[OutWidth-1]);
    end
  end

  always_comb begin
    state_d = state_q;
    dreq.start = 1'b0;
    dreq.dividend = a_q;
    dreq.divisor = b_q;
    case (state_q)
      SIdle: if (load) begin
        if (op_e'(in_i.opcode) == OpNone) state_d = SOut;
        else if (in_i.left_den == '0) state_d = SOut;
        else if (op_e'(in_i.opcode) != OpReduce && in_i.right_den == '0) state_d = SOut;
        else state_d = SGcdStart;
      end
      SGcdStart: begin
        if (b_q == '0) state_d = SDivAStart;
        else begin
          dreq.start = 1'b1;
          state_d = SGcdWait;
        end
      end
      SGcdWait: if (drsp.done) state_d = SGcdStart;
      SDivAStart: begin
        dreq.start = 1'b1;
        dreq.dividend = (op_e'(op_q) == OpReduce) ? mag(n1_q) : mag(d2_q);
        dreq.divisor = g_q;
        state_d = SDivAWait;
      end
      SDivAWait: if (drsp.done) state_d = SDivBStart;
      SDivBStart: begin
        dreq.start = 1'b1;
        dreq.dividend = mag(d1_q);
        dreq.divisor = g_q;
        state_d = SDivBWait;
      end
      SDivBWait: if (drsp.done) state_d = (op_e'(op_q) == OpReduce) ? SOut : SMul1;
      SMul1: state_d = SMul2;
      SMul2: state_d = SMul3;
      SMul3: state_d = SSum;
      SSum: state_d = SOut;
      SOut: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (state_q == SOut) begin
      vld_q <= 1'b1;
    end else if (out_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      op_q <= in_i.opcode;
      n1_q <= in_i.left_num;
      d1_q <= in_i.left_den;
      n2_q <= in_i.right_num;
      d2_q <= in_i.right_den;
      a_q <= ma_in;
      b_q <= mb_in;
      rnum_q <= '0;
      rden_q <= '0;
      status_q <= StOk;
      if (op_e'(in_i.opcode) != OpNone && (in_i.left_den == '0 ||
          (op_e'(in_i.opcode) != OpReduce && in_i.right_den == '0)))
        status_q <= StZeroDen;
    end
    case (state_q)
      SGcdStart: if (b_q == '0) g_q <= a_q;
      SGcdWait: if (drsp.done) begin
        a_q <= b_q;
        b_q <= drsp.remainder;
      end
      SDivAWait: if (drsp.done) qa_q <= drsp.quotient;
      SDivBWait: if (drsp.done) begin
        qb_q <= drsp.quotient;
        if (op_e'(op_q) == OpReduce) begin
          rnum_q <= OutWidth'(n1_q[InWidth-1] ? -$signed(qa_q) : $signed(qa_q));
          rden_q <= OutWidth'(d1_q[InWidth-1] ? -$signed(drsp.quotient) : $signed(drsp.quotient));
        end
      end
      SMul1: den_q <= OutWidth'(mul_p);
      SMul2: p1_q <= OutWidth'(mul_p);
      SMul3: p2_q <= OutWidth'(mul_p);
      SSum: begin
        if (ovf) status_q <= StOverflow;
        else begin
          rnum_q <= sum;
          rden_q <= den_q;
        end
      end
      default: ;
    endcase
  end

  fasr_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  assign out_o.valid = vld_q;
  assign out_o.result_num = rnum_q;
  assign out_o.result_den = rden_q;
  assign out_o.status = status_q;

  ap_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !in_i.ready) else $error("ready while busy");
  ap_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SOut) |-> !vld_q) else $error("result overwritten");
  ap_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (status_q != 2'd3)) else $error("bad status");

endmodule
